FILE: rtl/vie_pkg.sv
// Shared opcodes, flag positions, defaults and command type for the instruction execute block.
`default_nettype none

package vie_pkg;

  localparam int unsigned REG_COUNT_DEF = 16;
  localparam int unsigned PC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OPC_W  = 4;
  localparam int unsigned NPC_W  = 16;
  localparam int unsigned FLAG_W = 4;

  // Compare flag bit positions
  localparam int unsigned FLAG_NE_BIT = 3;
  localparam int unsigned FLAG_EQ_BIT = 2;
  localparam int unsigned FLAG_GT_BIT = 1;
  localparam int unsigned FLAG_LT_BIT = 0;

  typedef enum logic [OPC_W-1:0] {
    OP_HLT   = 4'd0,
    OP_MOV   = 4'd1,
    OP_MOVR  = 4'd2,
    OP_ADD   = 4'd3,
    OP_PRINT = 4'd4,
    OP_CALL  = 4'd5,
    OP_RET   = 4'd6,
    OP_CMP   = 4'd7,
    OP_JE    = 4'd8,
    OP_JNE   = 4'd9,
    OP_JG    = 4'd10,
    OP_JL    = 4'd11,
    OP_LABEL = 4'd12
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/vie_if.sv
// Request and response channel interfaces of the instruction execute block.
`default_nettype none

interface vie_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [3:0]  dst_reg;
  logic [3:0]  src_a_reg;
  logic [3:0]  src_b_reg;
  logic [31:0] operand_word;

  modport source(output valid, req_type, dst_reg, src_a_reg, src_b_reg, operand_word,
                 input ready);
  modport sink(input valid, req_type, dst_reg, src_a_reg, src_b_reg, operand_word,
               output ready);
endinterface

interface vie_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [3:0]  flags_out;
  logic        print_valid;
  logic [31:0] print_value;

  modport source(output valid, next_pc, flags_out, print_valid, print_value,
                 input ready);
  modport sink(input valid, next_pc, flags_out, print_valid, print_value,
               output ready);
endinterface

`default_nettype wire

FILE: rtl/vie_regfile.sv
// Register file: one write port, two registered read ports, per-entry valid bits.
`default_nettype none

module vie_regfile #(
  parameter int unsigned REG_COUNT = vie_pkg::REG_COUNT_DEF,
  parameter int unsigned IDX_W     = $clog2(REG_COUNT)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      re,
  input  wire logic [IDX_W-1:0]          raddr0,
  input  wire logic [IDX_W-1:0]          raddr1,
  output logic      [vie_pkg::WORD_W-1:0] rdata0,
  output logic      [vie_pkg::WORD_W-1:0] rdata1,
  input  wire logic                      we,
  input  wire logic [IDX_W-1:0]          waddr,
  input  wire logic [vie_pkg::WORD_W-1:0] wdata
);
  import vie_pkg::*;

  logic [WORD_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Write-first: a read in the cycle of a write to the same entry sees the new data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (we && waddr == raddr0) begin
        rdata0 <= wdata;
      end else begin
        rdata0 <= vld[raddr0] ? mem[raddr0] : '0;
      end
      if (we && waddr == raddr1) begin
        rdata1 <= wdata;
      end else begin
        rdata1 <= vld[raddr1] ? mem[raddr1] : '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vie_front.sv
// Front end: accept requests, decode opcode and register indices, queue commands.
`default_nettype none

module vie_front #(
  parameter int unsigned REG_COUNT = vie_pkg::REG_COUNT_DEF,
  parameter int unsigned IDX_W     = $clog2(REG_COUNT)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  vie_req_if.sink               req,
  output logic                  head_valid,
  input  wire logic             pop,
  output vie_pkg::cmd_t         head_cmd,
  output logic [IDX_W-1:0]      head_dst,
  output logic [IDX_W-1:0]      raddr0,
  output logic [IDX_W-1:0]      raddr1
);
  import vie_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [4:0]  WRAP_M = (REG_COUNT >= 16) ? 5'd16 : 5'(REG_COUNT);

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] dst;
    logic [IDX_W-1:0] src_a;
    logic [IDX_W-1:0] src_b;
  } entry_t;

  // Fold a 4-bit index into the register count (at most three subtractions)
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [3:0] v);
    logic [4:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 3; i++) begin
      if (t >= WRAP_M) begin
        t = t - WRAP_M;
      end
    end
    return IDX_W'(t);
  endfunction

  entry_t            q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  entry_t            in_entry;
  entry_t            head;
  logic              push;
  op_t               op_dec;

  always_comb begin
    if (req.req_type inside {[OP_HLT:OP_LABEL]}) begin
      op_dec = op_t'(req.req_type);
    end else begin
      op_dec = OP_LABEL;
    end
    in_entry.cmd.op   = op_dec;
    in_entry.cmd.word = req.operand_word;
    in_entry.dst      = wrap_idx(req.dst_reg);
    in_entry.src_a    = wrap_idx(req.src_a_reg);
    in_entry.src_b    = wrap_idx(req.src_b_reg);
  end

  assign req.ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign push       = req.valid && req.ready;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign head_cmd   = head.cmd;
  assign head_dst   = head.dst;

  // Port 0 always reads source A; port 1 reads source B for add, else the destination
  assign raddr0 = head.src_a;
  assign raddr1 = (head.cmd.op == OP_ADD) ? head.src_b : head.dst;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vie_back.sv
// Back end: execute stage, architectural state and response register.
`default_nettype none

module vie_back #(
  parameter int unsigned REG_COUNT = vie_pkg::REG_COUNT_DEF,
  parameter int unsigned PC_BITS   = vie_pkg::PC_BITS_DEF,
  parameter int unsigned IDX_W     = $clog2(REG_COUNT)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       head_valid,
  output logic                            pop,
  input  wire vie_pkg::cmd_t              head_cmd,
  input  wire logic [IDX_W-1:0]           head_dst,
  input  wire logic [vie_pkg::WORD_W-1:0] rdata0,
  input  wire logic [vie_pkg::WORD_W-1:0] rdata1,
  output logic                            we,
  output logic      [IDX_W-1:0]           waddr,
  output logic      [vie_pkg::WORD_W-1:0] wdata,
  vie_rsp_if.source                       rsp
);
  import vie_pkg::*;

  // Execute stage
  logic             x_valid;
  cmd_t             x_cmd;
  logic [IDX_W-1:0] x_dst;
  logic             x_fire;

  // Architectural state
  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] ret_addr;
  logic               called;
  logic [FLAG_W-1:0]  flags;

  logic [PC_BITS-1:0] pc_next;
  logic [PC_BITS-1:0] ret_addr_next;
  logic               called_next;
  logic [FLAG_W-1:0]  flags_next;
  logic [PC_BITS-1:0] pc_inc;
  logic [PC_BITS-1:0] target;
  logic               wr_en;
  logic               branch;
  logic               cond;
  logic               pv;
  logic [WORD_W-1:0]  pval;

  // Response register
  logic               out_valid;
  logic [NPC_W-1:0]   out_pc;
  logic [FLAG_W-1:0]  out_flags;
  logic               out_pv;
  logic [WORD_W-1:0]  out_pval;

  assign x_fire = x_valid && (!out_valid || rsp.ready);
  assign pop    = head_valid && (!x_valid || x_fire);

  assign pc_inc = pc + 1'b1;
  assign target = x_cmd.word[PC_BITS-1:0];

  always_comb begin
    pc_next       = pc;
    ret_addr_next = ret_addr;
    called_next   = called;
    flags_next    = flags;
    wr_en         = 1'b0;
    wdata         = x_cmd.word;
    branch        = 1'b0;
    cond          = 1'b0;
    pv            = 1'b0;
    pval          = '0;
    case (x_cmd.op)
      OP_MOV: begin
        wr_en   = 1'b1;
        pc_next = pc_inc;
      end
      OP_MOVR: begin
        wr_en = 1'b1;
        wdata = rdata0;
      end
      OP_ADD: begin
        wr_en = 1'b1;
        wdata = rdata0 + rdata1;
      end
      OP_PRINT: begin
        pv   = 1'b1;
        pval = rdata1;
      end
      OP_CALL: begin
        branch = 1'b1;
      end
      OP_RET: begin
        if (called) begin
          pc_next     = ret_addr;
          called_next = 1'b0;
        end
      end
      OP_CMP: begin
        flags_next              = '0;
        flags_next[FLAG_EQ_BIT] = (rdata1 == rdata0);
        flags_next[FLAG_NE_BIT] = (rdata1 != rdata0);
        flags_next[FLAG_GT_BIT] = (rdata1 > rdata0);
        flags_next[FLAG_LT_BIT] = (rdata1 < rdata0);
      end
      OP_JE, OP_JNE, OP_JG, OP_JL: begin
        case (x_cmd.op)
          OP_JE:   cond = flags[FLAG_EQ_BIT];
          OP_JNE:  cond = flags[FLAG_NE_BIT];
          OP_JG:   cond = flags[FLAG_GT_BIT];
          default: cond = flags[FLAG_LT_BIT];
        endcase
        if (cond) begin
          branch = 1'b1;
        end else begin
          pc_next = pc_inc;
        end
      end
      default: begin
      end
    endcase
    if (branch) begin
      ret_addr_next = pc_inc;
      called_next   = 1'b1;
      pc_next       = target;
    end
  end

  assign we    = x_fire && wr_en;
  assign waddr = x_dst;

  always_ff @(posedge clk) begin
    if (pop) begin
      x_cmd <= head_cmd;
      x_dst <= head_dst;
    end
    if (x_fire) begin
      out_pc    <= NPC_W'(pc_next);
      out_flags <= flags_next;
      out_pv    <= pv;
      out_pval  <= pval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid   <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      ret_addr  <= '0;
      called    <= 1'b0;
      flags     <= '0;
    end else begin
      if (pop) begin
        x_valid <= 1'b1;
      end else if (x_fire) begin
        x_valid <= 1'b0;
      end
      if (x_fire) begin
        out_valid <= 1'b1;
        pc        <= pc_next;
        ret_addr  <= ret_addr_next;
        called    <= called_next;
        flags     <= flags_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.next_pc     = out_pc;
  assign rsp.flags_out   = out_flags;
  assign rsp.print_valid = out_pv;
  assign rsp.print_value = out_pval;

endmodule

`default_nettype wire

FILE: rtl/vm_instruction_execute.sv
// Top level of the virtual-machine instruction execute block.
`default_nettype none

// Executes one decoded instruction per request and returns one response per
// request: the program counter after the instruction, the four compare flags
// and, for a debug print, the printed register value. The front end accepts a
// request, folds the register indices into the register count, maps unused
// opcodes to a no-op and pushes the command into a two-entry queue. The back
// end pops the queue, reads two register-file ports as it pops, executes and
// loads the response register. The block holds the register file (cleared by
// reset through per-entry valid bits), the program counter, one return
// address, the called mark and the compare flags. Throughput is one request
// per cycle while the response side is ready, bounded by the single execute
// stage; a request passes from acceptance through the queue, register read
// and execute stage into the response register. Requests keep being
// accepted while a response waits, until the queue and execute stage fill.

module vm_instruction_execute #(
  parameter int unsigned REG_COUNT = vie_pkg::REG_COUNT_DEF,
  parameter int unsigned PC_BITS   = vie_pkg::PC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  vie_req_if.sink   req,
  vie_rsp_if.source rsp
);
  import vie_pkg::*;

  localparam int unsigned IDX_W = $clog2(REG_COUNT);

  // Queue head toward the back end
  logic             head_valid;
  logic             pop;
  cmd_t             head_cmd;
  logic [IDX_W-1:0] head_dst;

  // Register-file ports
  logic [IDX_W-1:0]  raddr0;
  logic [IDX_W-1:0]  raddr1;
  logic [WORD_W-1:0] rdata0;
  logic [WORD_W-1:0] rdata1;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  // Accept, decode and queue
  vie_front #(
    .REG_COUNT (REG_COUNT),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .head_valid (head_valid),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_dst   (head_dst),
    .raddr0     (raddr0),
    .raddr1     (raddr1)
  );

  // Read on pop; the write from the execute stage bypasses into the read
  vie_regfile #(
    .REG_COUNT (REG_COUNT),
    .IDX_W     (IDX_W)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .re     (pop),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata)
  );

  // Execute, update state, hold the response
  vie_back #(
    .REG_COUNT (REG_COUNT),
    .PC_BITS   (PC_BITS),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_dst   (head_dst),
    .rdata0     (rdata0),
    .rdata1     (rdata1),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .rsp        (rsp)
  );

`ifndef SYNTHESIS
  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  // An accepted request leaves the queue non-empty in the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> head_valid)
    else $error("accepted request missing from queue");

  // An empty queue always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> req.ready)
    else $error("request refused with empty queue");
`endif

endmodule

`default_nettype wire
